### sv/uart_rx_ring_idle_framer_defines.svh
// assertion macros shared by the receive framer rtl
// no dependencies; clk and arst_n must exist in the module that uses them
`ifndef UART_RX_RING_IDLE_FRAMER_DEFINES_SVH
`define UART_RX_RING_IDLE_FRAMER_DEFINES_SVH
`ifndef ASSERT_OFF
`define URIF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error("urif assertion failed");
`define URIF_ASSERT_NOW(lbl, expr) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) \
		else $error("urif invariant broken");
`else
`define URIF_ASSERT(lbl, prop)
`define URIF_ASSERT_NOW(lbl, expr)
`endif
`endif

### sv/urif_pkg.sv
// types, constants and helpers for the receive ring framer
// no dependencies
package urif_pkg;

	localparam int unsigned BUFFER_DEPTH = 1024;
	localparam int unsigned PTR_W = $clog2(BUFFER_DEPTH);
	localparam int unsigned CFG_IDX_W = 1;

	typedef logic [PTR_W-1:0] ptr_t;

	// item operation codes
	typedef enum logic [1:0] {
		FUNC_BYTE = 2'd0,
		FUNC_TICK = 2'd1,
		FUNC_READ = 2'd2,
		FUNC_NOP  = 2'd3
	} func_t;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TIMEOUT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_HOLD_OLD     = 1'b1;

	localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd50;

	typedef struct packed {
		logic [7:0] idle_timeout_ticks;
		logic       hold_old_data;
	} cfg_t;

	typedef struct packed {
		logic       we;
		ptr_t       waddr;
		logic [7:0] wdata;
		logic       re;
		ptr_t       raddr;
	} mem_req_t;

	typedef struct packed {
		logic       accepted;
		logic       frame_ready;
		logic [7:0] read_byte;
		logic       read_valid;
		logic       read_last;
		logic       is_empty;
		logic       is_full;
		logic       is_locked;
	} res_t;

	// ring pointer step with wrap at the buffer end
	function automatic ptr_t ptr_advance(input ptr_t p);
		return (p == ptr_t'(BUFFER_DEPTH - 1)) ? '0 : p + ptr_t'(1);
	endfunction

endpackage

### sv/urif_chan_if.sv
// handshake channels of the receive ring framer: item, result and config
// depends on urif_pkg for the config index width
interface urif_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] rx_byte;
	modport source (output valid, func, rx_byte, input ready);
	modport sink (input valid, func, rx_byte, output ready);
endinterface

interface urif_result_if;
	logic       valid;
	logic       ready;
	logic       accepted;
	logic       frame_ready;
	logic [7:0] read_byte;
	logic       read_valid;
	logic       read_last;
	logic       is_empty;
	logic       is_full;
	logic       is_locked;
	modport source (output valid, accepted, frame_ready, read_byte, read_valid, read_last,
		is_empty, is_full, is_locked, input ready);
	modport sink (input valid, accepted, frame_ready, read_byte, read_valid, read_last,
		is_empty, is_full, is_locked, output ready);
endinterface

interface urif_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [urif_pkg::CFG_IDX_W-1:0] index;
	logic [7:0]                     data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

### sv/urif_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module urif_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, registered read data
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### sv/urif_ctrl.sv
// ring pointers, status flags, idle countdown and result register
// depends on urif_pkg, urif_chan_if and the assertion macro header
`include "uart_rx_ring_idle_framer_defines.svh"

module urif_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	urif_item_if.sink           item,
	urif_result_if.source       result,
	input  urif_pkg::cfg_t      cfg,
	output urif_pkg::mem_req_t  mem_req,
	input  logic [7:0]          mem_rdata
);

	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_READ = 2'b10
	} state_t;

	state_t            state_q;
	urif_pkg::ptr_t    wr_ptr_q, rd_ptr_q, wr_ptr_n, rd_ptr_n;
	logic              empty_q, full_q, locked_q, ready_q;
	logic              empty_n, full_n, locked_n, ready_n;
	logic [7:0]        cnt_q, cnt_n;
	logic              out_valid_q;
	urif_pkg::res_t    res_q, res_n;
	urif_pkg::func_t   func;
	logic              accept;

	assign func   = urif_pkg::func_t'(item.func);
	assign accept = item.valid && item.ready;

	// one item in flight; a read waits in S_READ for the ram
	assign item.ready = (state_q == S_IDLE) && (!out_valid_q || result.ready);

	// next state of the ring for the item on the input
	always_comb begin
		wr_ptr_n = wr_ptr_q;
		rd_ptr_n = rd_ptr_q;
		empty_n  = empty_q;
		full_n   = full_q;
		locked_n = locked_q;
		ready_n  = ready_q;
		cnt_n    = cnt_q;
		res_n    = '0;
		mem_req  = '0;
		mem_req.waddr = wr_ptr_q;
		mem_req.wdata = item.rx_byte;
		mem_req.raddr = rd_ptr_q;
		case (func)
			urif_pkg::FUNC_BYTE: begin
				cnt_n = cfg.idle_timeout_ticks;
				if (locked_q) begin
					// rejected byte ends the frame
					cnt_n   = '0;
					ready_n = 1'b1;
				end else begin
					mem_req.we      = accept;
					wr_ptr_n        = urif_pkg::ptr_advance(wr_ptr_q);
					res_n.accepted  = 1'b1;
					if (empty_q) begin
						empty_n = 1'b0;
					end else if (full_q) begin
						rd_ptr_n = wr_ptr_n;
					end else if (wr_ptr_n == rd_ptr_q) begin
						if (cfg.hold_old_data) begin
							locked_n = 1'b1;
						end else begin
							full_n = 1'b1;
						end
					end
				end
			end
			urif_pkg::FUNC_TICK: begin
				if (cnt_q != '0) begin
					cnt_n = cnt_q - 8'd1;
					if (cnt_q == 8'd1) begin
						ready_n = 1'b1;
					end
				end
			end
			urif_pkg::FUNC_READ: begin
				ready_n = 1'b0;
				if (!empty_q) begin
					mem_req.re       = accept;
					res_n.read_valid = 1'b1;
					rd_ptr_n         = urif_pkg::ptr_advance(rd_ptr_q);
					if (rd_ptr_n == wr_ptr_q) begin
						empty_n         = 1'b1;
						res_n.read_last = 1'b1;
					end
				end
				full_n   = 1'b0;
				locked_n = 1'b0;
			end
			default: begin
			end
		endcase
		res_n.frame_ready = ready_n;
		res_n.is_empty    = empty_n;
		res_n.is_full     = full_n;
		res_n.is_locked   = locked_n;
	end

	// ring state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			empty_q  <= 1'b1;
			full_q   <= 1'b0;
			locked_q <= 1'b0;
			ready_q  <= 1'b0;
			cnt_q    <= '0;
		end else if (accept) begin
			wr_ptr_q <= wr_ptr_n;
			rd_ptr_q <= rd_ptr_n;
			empty_q  <= empty_n;
			full_q   <= full_n;
			locked_q <= locked_n;
			ready_q  <= ready_n;
			cnt_q    <= cnt_n;
		end
	end

	// sequencer: a read waits in S_READ for ram data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept && func == urif_pkg::FUNC_READ) begin
						state_q <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && func != urif_pkg::FUNC_READ) begin
			out_valid_q <= 1'b1;
		end else if (state_q == S_READ) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload; read data merged in once the ram returns it
	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= res_n;
		end else if (state_q == S_READ) begin
			res_q.read_byte <= res_q.read_valid ? mem_rdata : 8'd0;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.accepted    = res_q.accepted;
	assign result.frame_ready = res_q.frame_ready;
	assign result.read_byte   = res_q.read_byte;
	assign result.read_valid  = res_q.read_valid;
	assign result.read_last   = res_q.read_last;
	assign result.is_empty    = res_q.is_empty;
	assign result.is_full     = res_q.is_full;
	assign result.is_locked   = res_q.is_locked;

	`URIF_ASSERT_NOW(a_full_locked_excl, !(full_q && locked_q))
	`URIF_ASSERT_NOW(a_empty_ptrs_equal, !empty_q || (rd_ptr_q == wr_ptr_q))
	`URIF_ASSERT(a_read_slot_free, (state_q == S_READ) |-> !out_valid_q)
	`URIF_ASSERT(a_read_gives_beat, (accept && func == urif_pkg::FUNC_READ) |=> ##1 out_valid_q)
	`URIF_ASSERT_NOW(a_write_only_on_byte, !mem_req.we || (accept && func == urif_pkg::FUNC_BYTE))

endmodule

### sv/uart_rx_ring_idle_framer.sv
// receive ring buffer with idle-timeout frame marking, 1024 x 8 byte store in ram.
// byte, tick and no-op results are registered; read results first pass the S_READ
// state, since the ram read port is registered; no new item is taken in S_READ.
// throughput: one item per cycle for byte and tick items while results are taken.
// reset: pointers, flags and countdown cleared, timeout 50, overwrite policy;
// the byte store is not cleared and needs no clearing pass.
module uart_rx_ring_idle_framer (
	input  logic          clk,
	input  logic          arst_n,
	urif_item_if.sink     item,
	urif_result_if.source result,
	urif_cfg_if.sink      cfg
);

	urif_pkg::cfg_t     cfg_q;
	urif_pkg::mem_req_t mem_req;
	logic [7:0]         mem_rdata;

	assign cfg.ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.idle_timeout_ticks <= urif_pkg::IDLE_TIMEOUT_RESET;
			cfg_q.hold_old_data      <= 1'b0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				urif_pkg::CFG_IDLE_TIMEOUT: cfg_q.idle_timeout_ticks <= cfg.data;
				urif_pkg::CFG_HOLD_OLD:     cfg_q.hold_old_data      <= cfg.data[0];
				default: begin
				end
			endcase
		end
	end

	// pointer, flag and result control
	urif_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg       (cfg_q),
		.mem_req   (mem_req),
		.mem_rdata (mem_rdata)
	);

	// byte store
	urif_ram #(
		.WIDTH (8),
		.DEPTH (urif_pkg::BUFFER_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (mem_rdata)
	);

endmodule

### tb/uart_rx_ring_idle_framer_tb.sv
// self-checking testbench for the receive ring framer: directed and random item streams
// depends on urif_pkg, the urif channel interfaces and uart_rx_ring_idle_framer
// every result beat is checked field by field against an in-bench ring predictor
module uart_rx_ring_idle_framer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import urif_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned RANDOM_ITEMS = 60;
	localparam int unsigned NEAR_FULL = BUFFER_DEPTH - 2;
	localparam int unsigned NEAR_EMPTY = 3;

	typedef enum int {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_mode_t;

	logic clk;
	logic arst_n;

	urif_item_if   item_ch ();
	urif_result_if res_ch ();
	urif_cfg_if    cfg_ch ();

	uart_rx_ring_idle_framer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	// shadow ring state
	logic [7:0] shadow_mem [BUFFER_DEPTH];
	ptr_t       wr_ptr = '0;
	ptr_t       rd_ptr = '0;
	bit         flg_empty = 1'b1;
	bit         flg_full = 1'b0;
	bit         flg_locked = 1'b0;
	logic [7:0] countdown = '0;
	bit         frame_flag = 1'b0;
	logic [7:0] cfg_timeout = IDLE_TIMEOUT_RESET;
	bit         cfg_hold = 1'b0;

	res_t        outcome_q [$];
	int unsigned items_sent = 0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;
	int unsigned send_idle_pct = 0;
	int unsigned stall_pct = 0;

	always #4 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAIL uart_rx_ring_idle_framer");
			$finish;
		end
	end

	// result side back-pressure
	always @(posedge clk) begin
		res_ch.ready <= arst_n && ($urandom_range(99) >= stall_pct);
	end

	// bytes currently held in the ring
	function automatic int unsigned fill_level();
		if (flg_empty)
			return 0;
		if (wr_ptr == rd_ptr)
			return BUFFER_DEPTH;
		return int'(ptr_t'(wr_ptr - rd_ptr));
	endfunction

	// advance the shadow ring by one item and return the status it reports
	function automatic res_t ring_step_outcome(input func_t f, input logic [7:0] b);
		res_t r;
		r = '0;
		case (f)
			FUNC_BYTE: begin
				countdown = cfg_timeout;
				if (flg_locked) begin
					countdown = '0;
					frame_flag = 1'b1;
				end else begin
					shadow_mem[wr_ptr] = b;
					wr_ptr = wr_ptr + 1'b1;
					r.accepted = 1'b1;
					if (flg_empty)
						flg_empty = 1'b0;
					else if (flg_full)
						rd_ptr = wr_ptr;
					else if (wr_ptr == rd_ptr) begin
						if (cfg_hold)
							flg_locked = 1'b1;
						else
							flg_full = 1'b1;
					end
				end
			end
			FUNC_TICK: begin
				if (countdown != 0) begin
					countdown = countdown - 1'b1;
					if (countdown == 0)
						frame_flag = 1'b1;
				end
			end
			FUNC_READ: begin
				frame_flag = 1'b0;
				if (!flg_empty) begin
					r.read_byte = shadow_mem[rd_ptr];
					r.read_valid = 1'b1;
					rd_ptr = rd_ptr + 1'b1;
					if (rd_ptr == wr_ptr) begin
						flg_empty = 1'b1;
						r.read_last = 1'b1;
					end
				end
				flg_full = 1'b0;
				flg_locked = 1'b0;
			end
			default: ;
		endcase
		r.frame_ready = frame_flag;
		r.is_empty = flg_empty;
		r.is_full = flg_full;
		r.is_locked = flg_locked;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0h, actual %0h", name, want, got);
			mismatches++;
		end
	endfunction

	// compare each result beat with the oldest prediction
	always @(posedge clk) begin : check_results
		res_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (outcome_q.size() == 0) begin
				$error("result beat arrived with no prediction outstanding");
				mismatches++;
			end else begin
				want = outcome_q.pop_front();
				check_field("accepted", 8'(want.accepted), 8'(res_ch.accepted));
				check_field("frame_ready", 8'(want.frame_ready), 8'(res_ch.frame_ready));
				check_field("read_byte", want.read_byte, res_ch.read_byte);
				check_field("read_valid", 8'(want.read_valid), 8'(res_ch.read_valid));
				check_field("read_last", 8'(want.read_last), 8'(res_ch.read_last));
				check_field("is_empty", 8'(want.is_empty), 8'(res_ch.is_empty));
				check_field("is_full", 8'(want.is_full), 8'(res_ch.is_full));
				check_field("is_locked", 8'(want.is_locked), 8'(res_ch.is_locked));
			end
		end
	end

	task automatic set_idle_mode(input idle_mode_t mode);
		case (mode)
			IDLE_NONE:     begin send_idle_pct = 0;  stall_pct = 0;  end
			IDLE_SENDER:   begin send_idle_pct = 70; stall_pct = 0;  end
			IDLE_RECEIVER: begin send_idle_pct = 0;  stall_pct = 70; end
			default:       begin send_idle_pct = 26; stall_pct = 26; end
		endcase
	endtask

	// one item beat; valid stays high for a following beat
	task automatic send_item(input func_t f, input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			item_ch.valid <= 1'b0;
			@(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.rx_byte <= b;
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		outcome_q.push_back(ring_step_outcome(f, b));
		items_sent++;
	endtask

	// stop sending and let every outstanding result come back
	task automatic wait_idle();
		item_ch.valid <= 1'b0;
		while (outcome_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// both registers back to back, only with the block idle
	task automatic write_config(input logic [7:0] timeout, input bit hold);
		wait_idle();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= CFG_IDLE_TIMEOUT;
		cfg_ch.data <= timeout;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_timeout = timeout;
		cfg_ch.index <= CFG_HOLD_OLD;
		cfg_ch.data <= {7'($urandom), hold};
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_hold = hold;
		cfg_ch.valid <= 1'b0;
	endtask

	// mixed bursts steered towards a fill level
	task automatic run_random(input int unsigned n_items, input int unsigned target);
		int unsigned first;
		int unsigned pick;
		int unsigned len;
		func_t       f;
		first = items_sent;
		while (items_sent - first < n_items) begin
			pick = $urandom_range(99);
			if (pick < 10) begin
				// tick runs, often landing exactly on the end of the countdown
				if (countdown != 0 && $urandom_range(1))
					len = countdown + $urandom_range(1);
				else
					len = $urandom_range(1, 3);
				repeat (len) send_item(FUNC_TICK, 8'($urandom));
			end else if (pick < 14) begin
				send_item(FUNC_NOP, 8'($urandom));
			end else begin
				f = ($urandom_range(99) < ((fill_level() < target) ? 70 : 30)) ?
					FUNC_BYTE : FUNC_READ;
				repeat ($urandom_range(1, 6)) send_item(f, 8'($urandom));
			end
		end
	endtask

	// reset timeout of 50 ticks, run under the default overwrite policy
	task automatic test_default_timeout();
		set_idle_mode(IDLE_NONE);
		send_item(FUNC_BYTE, 8'h00);
		repeat (50) send_item(FUNC_TICK, 8'($urandom));
		send_item(FUNC_READ, 8'($urandom));
	endtask

	// every operation, byte extremes, short and zero timeouts, empty reads
	task automatic test_directed();
		set_idle_mode(IDLE_NONE);
		write_config(8'd1, 1'b0);
		send_item(FUNC_NOP, 8'h00);
		send_item(FUNC_READ, 8'hFF);
		send_item(FUNC_BYTE, 8'hFF);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_TICK, 8'h00);
		send_item(FUNC_BYTE, 8'h00);
		send_item(FUNC_READ, 8'h00);
		send_item(FUNC_READ, 8'h00);
		send_item(FUNC_READ, 8'h00);
		write_config(8'd0, 1'b1);
		send_item(FUNC_BYTE, 8'h55);
		send_item(FUNC_TICK, 8'hAA);
		send_item(FUNC_TICK, 8'hAA);
		send_item(FUNC_NOP, 8'hFF);
		send_item(FUNC_READ, 8'h55);
		write_config(8'd255, 1'b0);
		send_item(FUNC_BYTE, 8'hAA);
		send_item(FUNC_TICK, 8'h55);
		send_item(FUNC_READ, 8'h00);
	endtask

	// hold policy: fill to lock, rejected bytes, unlock by a read, lock again
	task automatic test_hold_lock();
		set_idle_mode(IDLE_BOTH);
		write_config(8'd255, 1'b1);
		while (!flg_locked)
			send_item(FUNC_BYTE, 8'($urandom));
		repeat (3) send_item(FUNC_BYTE, 8'($urandom));
		send_item(FUNC_TICK, 8'($urandom));
		send_item(FUNC_READ, 8'($urandom));
		send_item(FUNC_BYTE, 8'($urandom));
		send_item(FUNC_BYTE, 8'($urandom));
		send_item(FUNC_TICK, 8'($urandom));
	endtask

	// overwrite policy starting from a locked ring, then wrapping the oldest bytes
	task automatic test_overwrite();
		set_idle_mode(IDLE_SENDER);
		write_config(8'd2, 1'b0);
		send_item(FUNC_BYTE, 8'($urandom));
		send_item(FUNC_READ, 8'($urandom));
		repeat (21) send_item(FUNC_BYTE, 8'($urandom));
		repeat (2) send_item(FUNC_TICK, 8'($urandom));
		repeat (3) send_item(FUNC_READ, 8'($urandom));
		repeat (4) send_item(FUNC_BYTE, 8'($urandom));
	endtask

	// empty the ring, then read past the end
	task automatic test_drain();
		set_idle_mode(IDLE_RECEIVER);
		while (!flg_empty)
			send_item(FUNC_READ, 8'($urandom));
		repeat (2) send_item(FUNC_READ, 8'($urandom));
	endtask

	task automatic test_random_near_full();
		set_idle_mode(IDLE_NONE);
		write_config(8'($urandom_range(1, 8)), 1'b1);
		run_random(RANDOM_ITEMS, NEAR_FULL);
		set_idle_mode(IDLE_SENDER);
		write_config(8'd0, 1'b0);
		run_random(RANDOM_ITEMS, BUFFER_DEPTH);
	endtask

	task automatic test_random_near_empty();
		set_idle_mode(IDLE_RECEIVER);
		write_config(8'd255, 1'b1);
		run_random(RANDOM_ITEMS, NEAR_EMPTY);
		set_idle_mode(IDLE_BOTH);
		write_config(8'($urandom_range(1, 20)), 1'b0);
		run_random(RANDOM_ITEMS, NEAR_EMPTY);
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		item_ch.valid = 1'b0;
		item_ch.func = FUNC_NOP;
		item_ch.rx_byte = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = CFG_IDLE_TIMEOUT;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// low fill work first, so the ring is filled and drained only once
		test_default_timeout();
		test_directed();
		test_random_near_empty();
		test_drain();
		test_hold_lock();
		test_overwrite();
		test_random_near_full();

		wait_idle();
		if (mismatches == 0)
			$display("PASS uart_rx_ring_idle_framer");
		else
			$display("FAIL uart_rx_ring_idle_framer");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/urif_pkg.sv
sv/urif_chan_if.sv
sv/urif_ram.sv
sv/urif_ctrl.sv
sv/uart_rx_ring_idle_framer.sv
tb/uart_rx_ring_idle_framer_tb.sv
